// ===== sv/sha1sh_pkg.sv =====
// sha1 stream hasher package: constants, command struct and state types
`timescale 1ns / 1ps

package sha1sh_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int ROUNDS     = 80;

    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_END = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic {
        CMD_WORD,
        CMD_LAST
    } t_cmd_kind;

    // one queue entry: a full message word, or the closing partial word
    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] word;
        logic [1:0]  nbytes;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_bstate;

endpackage

// ===== sv/sha1sh_ifs.sv =====
// stream interfaces for the byte input and the digest output
`timescale 1ns / 1ps

interface sha1sh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;

    modport source (output valid, data_byte, byte_present, is_last, input ready);
    modport sink   (input valid, data_byte, byte_present, is_last, output ready);
endinterface

interface sha1sh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha1sh_fifo.sv =====
// command queue between the byte packer and the compression engine
`timescale 1ns / 1ps

module sha1sh_fifo
    import sha1sh_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/sha1sh_front.sv =====
// byte packer: gathers bytes into words and queues word and close commands
`timescale 1ns / 1ps

module sha1sh_front
    import sha1sh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha1sh_in_if.sink i_in,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full
);

    logic [31:0] r_part;
    logic [1:0]  r_nb;
    logic        r_last_pend;

    logic [31:0] n_part;
    logic [1:0]  n_nb;
    logic        n_last_pend;
    logic        accept;
    logic [31:0] merged;

    assign i_in.ready = !r_last_pend && !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign merged     = r_part | ({24'd0, i_in.data_byte} << (5'd24 - {r_nb, 3'b000}));

    always_comb begin
        n_part      = r_part;
        n_nb        = r_nb;
        n_last_pend = r_last_pend;
        o_push      = 1'b0;
        o_cmd       = '{kind: CMD_WORD, word: merged, nbytes: r_nb};
        if (r_last_pend) begin
            o_cmd = '{kind: CMD_LAST, word: 32'd0, nbytes: 2'd0};
            if (!i_full) begin
                o_push      = 1'b1;
                n_last_pend = 1'b0;
            end
        end else if (accept) begin
            if (i_in.byte_present) begin
                if (r_nb == 2'd3) begin
                    // word complete; a close in the same transfer is queued later from the registered pending flag
                    o_push      = 1'b1;
                    o_cmd       = '{kind: CMD_WORD, word: merged, nbytes: 2'd0};
                    n_part      = 32'd0;
                    n_nb        = 2'd0;
                    n_last_pend = i_in.is_last;
                end else if (i_in.is_last) begin
                    o_push = 1'b1;
                    o_cmd  = '{kind: CMD_LAST, word: merged, nbytes: r_nb + 2'd1};
                    n_part = 32'd0;
                    n_nb   = 2'd0;
                end else begin
                    n_part = merged;
                    n_nb   = r_nb + 2'd1;
                end
            end else if (i_in.is_last) begin
                o_push = 1'b1;
                o_cmd  = '{kind: CMD_LAST, word: r_part, nbytes: r_nb};
                n_part = 32'd0;
                n_nb   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part      <= 32'd0;
            r_nb        <= 2'd0;
            r_last_pend <= 1'b0;
        end else begin
            r_part      <= n_part;
            r_nb        <= n_nb;
            r_last_pend <= n_last_pend;
        end
    end

endmodule

// ===== sv/sha1sh_back.sv =====
// compression engine: block schedule, 80 rounds, padding and digest output
`timescale 1ns / 1ps

module sha1sh_back
    import sha1sh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    sha1sh_out_if.source o_out
);

    t_bstate     r_state;
    t_bstate     n_state;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;
    logic [3:0]  r_wcnt;
    logic [63:0] r_bitcnt;
    logic        r_final;
    logic        r_need_extra;
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_oindex;
    logic        r_olast;

    logic [31:0] n_h [5];
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [6:0]  n_round;
    logic [3:0]  n_wcnt;
    logic [63:0] n_bitcnt;
    logic        n_final;
    logic        n_need_extra;
    logic [2:0]  n_oidx;
    logic        shift_en;
    logic [31:0] shift_word;
    logic        oload;
    logic        round_done;

    logic [31:0] pad_word;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] sched_x;

    assign round_done = (r_round == 7'(ROUNDS - 1));
    assign oload      = (r_state == ST_OUT) && (!r_ovalid || o_out.ready);
    assign pad_word   = i_cmd.word | ({24'd0, PAD_BYTE} << (5'd24 - {i_cmd.nbytes, 3'b000}));

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_CH;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_PAR;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_MAJ;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_END;
        end
    end

    assign t_val   = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
    assign sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (r_wcnt == 4'd15) begin
                        n_state = ST_ROUND;
                    end else if (i_cmd.kind == CMD_LAST) begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (r_need_extra) begin
                    if (r_wcnt == 4'd15) begin
                        n_state = ST_ROUND;
                    end
                end else if (r_wcnt == 4'd14) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: n_state = ST_ROUND;
            ST_ROUND: begin
                if (round_done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_final && r_need_extra) begin
                    n_state = ST_FILL;
                end else if (r_final) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (oload && r_oidx == 3'd4) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_h          = r_h;
        n_a          = r_a;
        n_b          = r_b;
        n_c          = r_c;
        n_d          = r_d;
        n_e          = r_e;
        n_round      = r_round;
        n_wcnt       = r_wcnt;
        n_bitcnt     = r_bitcnt;
        n_final      = r_final;
        n_need_extra = r_need_extra;
        n_oidx       = r_oidx;
        shift_en     = 1'b0;
        shift_word   = 32'd0;
        o_pop        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop    = 1'b1;
                    shift_en = 1'b1;
                    n_wcnt   = r_wcnt + 4'd1;
                    if (i_cmd.kind == CMD_WORD) begin
                        shift_word = i_cmd.word;
                        n_bitcnt   = r_bitcnt + 64'd32;
                    end else begin
                        shift_word   = pad_word;
                        n_bitcnt     = r_bitcnt + {59'd0, i_cmd.nbytes, 3'b000};
                        n_final      = 1'b1;
                        n_need_extra = (r_wcnt >= 4'd14);
                    end
                end
            end
            ST_FILL: begin
                shift_en   = 1'b1;
                n_wcnt     = r_wcnt + 4'd1;
                shift_word = (!r_need_extra && r_wcnt == 4'd14) ? r_bitcnt[63:32] : 32'd0;
            end
            ST_LEN: begin
                shift_en   = 1'b1;
                n_wcnt     = r_wcnt + 4'd1;
                shift_word = r_bitcnt[31:0];
            end
            ST_ROUND: begin
                shift_en   = 1'b1;
                shift_word = {sched_x[30:0], sched_x[31]};
                n_a        = t_val;
                n_b        = r_a;
                n_c        = {r_b[1:0], r_b[31:2]};
                n_d        = r_c;
                n_e        = r_d;
                n_round    = round_done ? 7'd0 : r_round + 7'd1;
            end
            ST_ADD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_h[4] = r_h[4] + r_e;
                if (r_final && r_need_extra) begin
                    n_need_extra = 1'b0;
                end
            end
            ST_OUT: begin
                if (oload) begin
                    if (r_oidx == 3'd4) begin
                        n_oidx   = 3'd0;
                        n_h      = IV;
                        n_bitcnt = 64'd0;
                        n_final  = 1'b0;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: ;
        endcase
        if (n_state == ST_ROUND && r_state != ST_ROUND) begin
            n_a = r_h[0];
            n_b = r_h[1];
            n_c = r_h[2];
            n_d = r_h[3];
            n_e = r_h[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= shift_word;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_e <= n_e;
        if (oload) begin
            r_oword  <= r_h[r_oidx];
            r_oindex <= r_oidx;
            r_olast  <= (r_oidx == 3'd4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_h          <= IV;
            r_round      <= 7'd0;
            r_wcnt       <= 4'd0;
            r_bitcnt     <= 64'd0;
            r_final      <= 1'b0;
            r_need_extra <= 1'b0;
            r_oidx       <= 3'd0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_h          <= n_h;
            r_round      <= n_round;
            r_wcnt       <= n_wcnt;
            r_bitcnt     <= n_bitcnt;
            r_final      <= n_final;
            r_need_extra <= n_need_extra;
            r_oidx       <= n_oidx;
            if (oload) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_oword;
    assign o_out.word_index  = r_oindex;
    assign o_out.last_word   = r_olast;

endmodule

// ===== sv/sha1_stream_hasher.sv =====
// streaming sha-1 hasher over a byte stream
// usage:
//   i_in carries one message byte per transfer (data_byte with byte_present),
//   most significant byte first; is_last closes the message, with or without
//   a byte in the same transfer. o_out returns the digest as five transfers,
//   word_index 0 to 4, h0 first, last_word set on the fifth.
// timing:
//   the byte packer takes one transfer per cycle while the command queue has
//   room and no close is pending; every fourth byte becomes one queued word.
//   the engine, while idle, loads one word per cycle as long as the queue holds
//   one, then runs 80 rounds plus an add step per 64-byte block; the four-word
//   queue fills during the rounds. a closing transfer adds padding and the
//   length, one or two compressions, then five digest transfers; the input
//   keeps filling the queue meanwhile.
// reset:
//   synchronous active-low reset empties the queue, drops any partial message
//   and loads the initial hash words.
// stall:
//   if o_out.ready is low the digest word holds in the output register, the
//   engine waits, and once the queue fills i_in.ready drops.
`timescale 1ns / 1ps

module sha1_stream_hasher
    import sha1sh_pkg::*;
#(
    parameter int P_FIFO_DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sha1sh_in_if.sink    i_in,
    sha1sh_out_if.source o_out
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic pop;
    logic cmd_valid;
    t_cmd cmd;

    sha1sh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    sha1sh_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_data  (cmd)
    );

    sha1sh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
